// ===== rtl/mbg_pkg.sv =====
// Shared constants, types and width helpers for the monomial basis block.
package mbg_pkg;

  // Default build limit on polynomial degree
  localparam int MAX_DEGREE_DEF = 4;

  // Field widths
  localparam int CFG_W = 3;
  localparam int CRD_W = 32;
  localparam int IDX_W = 4;
  localparam int PHI_W = 32;
  localparam int DER_W = 48;

  // Fixed-point positions
  localparam int FRAC    = 30;
  localparam int SHIFT_G = 22;
  localparam int SPLIT   = 20;

  // Reset value of the degree register
  localparam logic [CFG_W-1:0] DEGREE_RST = 3'd1;

  // Front sequencer states
  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_ACC,
    F_PUSH
  } front_state_e;

  // Inverse Jacobian entries carried along the back pipeline
  typedef struct packed {
    logic signed [CRD_W-1:0] j11;
    logic signed [CRD_W-1:0] j12;
    logic signed [CRD_W-1:0] j21;
    logic signed [CRD_W-1:0] j22;
  } jinv_t;

  // Power width: |x^k| stays below 2^(30+k)
  function automatic int pw_of(int d);
    return CRD_W + d;
  endfunction

  // Derivative power width: k*x^(k-1), k below 16
  function automatic int dw_of(int d);
    return CRD_W + d + 4;
  endfunction

  // Local gradient width
  function automatic int gw_of(int d);
    return CRD_W + d + 3;
  endfunction

  // Bits needed for a degree 0..d
  function automatic int dg_of(int d);
    return (d < 2) ? 1 : $clog2(d + 1);
  endfunction

  // Width of one queue entry: four power tables, the matrix and the degree
  function automatic int entry_w(int d);
    return 2 * (d + 1) * (pw_of(d) + dw_of(d)) + 4 * CRD_W + dg_of(d);
  endfunction

endpackage

// ===== rtl/mbg_in_if.sv =====
// Input channel: reference point and inverse Jacobian, one beat per point.
interface mbg_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [mbg_pkg::CRD_W-1:0]   x_coord;
  logic signed [mbg_pkg::CRD_W-1:0]   y_coord;
  logic signed [mbg_pkg::CRD_W-1:0]   jinv_11;
  logic signed [mbg_pkg::CRD_W-1:0]   jinv_12;
  logic signed [mbg_pkg::CRD_W-1:0]   jinv_21;
  logic signed [mbg_pkg::CRD_W-1:0]   jinv_22;

  modport source (
    output valid, x_coord, y_coord, jinv_11, jinv_12, jinv_21, jinv_22,
    input  ready
  );
  modport sink (
    input  valid, x_coord, y_coord, jinv_11, jinv_12, jinv_21, jinv_22,
    output ready
  );
endinterface

// ===== rtl/mbg_out_if.sv =====
// Output channel: one basis function with its global gradient per beat.
interface mbg_out_if;
  logic                               valid;
  logic                               ready;
  logic        [mbg_pkg::IDX_W-1:0]   basis_index;
  logic signed [mbg_pkg::PHI_W-1:0]   phi_value;
  logic signed [mbg_pkg::DER_W-1:0]   dphi_dx;
  logic signed [mbg_pkg::DER_W-1:0]   dphi_dy;
  logic                               last_of_run;
  logic                               saturated;

  modport source (
    output valid, basis_index, phi_value, dphi_dx, dphi_dy, last_of_run, saturated,
    input  ready
  );
  modport sink (
    input  valid, basis_index, phi_value, dphi_dx, dphi_dy, last_of_run, saturated,
    output ready
  );
endinterface

// ===== rtl/mbg_fifo.sv =====
// Two-entry queue between the power builder and the basis pipeline.
module mbg_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             head_valid_o,
  output logic [Width-1:0] head_data_o,
  input  logic             pop_i
);

  logic [Width-1:0] mem_q [2];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             push, pop;

  // Occupancy and pointers
  always_comb begin
    push_ready_o = (cnt_q != 2'd2);
    head_valid_o = (cnt_q != 2'd0);
    head_data_o  = mem_q[rd_q];
    push         = push_valid_i & push_ready_o;
    pop          = pop_i & head_valid_o;
    wr_d         = push ? ~wr_q : wr_q;
    rd_d         = pop ? ~rd_q : rd_q;
    cnt_d        = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/mbg_front.sv =====
// Front end: takes a point, builds the power and derivative tables, queues them.
module mbg_front #(
  parameter  int MaxDegree = mbg_pkg::MAX_DEGREE_DEF,
  localparam int EntryW    = mbg_pkg::entry_w(MaxDegree)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [mbg_pkg::CFG_W-1:0] degree_i,
  mbg_in_if.sink                    in_ch,
  output logic                      push_valid_o,
  input  logic                      push_ready_i,
  output logic [EntryW-1:0]         push_data_o
);

  localparam int PW   = mbg_pkg::pw_of(MaxDegree);
  localparam int DW   = mbg_pkg::dw_of(MaxDegree);
  localparam int DGW  = mbg_pkg::dg_of(MaxDegree);
  localparam int CW   = mbg_pkg::CRD_W;
  localparam int SPL  = mbg_pkg::SPLIT;
  localparam int MW   = PW + CW;
  localparam int HW   = PW - SPL + CW;
  localparam int LW   = SPL + 1 + CW;
  localparam int OffPy = (MaxDegree + 1) * PW;
  localparam int OffDx = 2 * (MaxDegree + 1) * PW;
  localparam int OffDy = OffDx + (MaxDegree + 1) * DW;
  localparam int OffJ  = OffDy + (MaxDegree + 1) * DW;
  localparam int OffDg = OffJ + 4 * CW;

  localparam logic signed [PW-1:0] OneQ  = PW'(1) <<< mbg_pkg::FRAC;
  localparam logic signed [MW-1:0] HalfM = MW'(1) <<< (mbg_pkg::FRAC - 1);

  mbg_pkg::front_state_e state_q, state_d;

  logic                   accept;
  logic [DGW-1:0]         deg_in, deg_q, k_q, km1;
  logic signed [CW-1:0]   x_q, y_q;
  mbg_pkg::jinv_t         jv_q;
  logic signed [PW-1:0]   px_q [MaxDegree+1];
  logic signed [PW-1:0]   py_q [MaxDegree+1];
  logic signed [DW-1:0]   dx_q [MaxDegree+1];
  logic signed [DW-1:0]   dy_q [MaxDegree+1];
  logic signed [PW-1:0]   px_prev, py_prev;
  logic signed [HW-1:0]   mx_hi_q, my_hi_q;
  logic signed [LW-1:0]   mx_lo_q, my_lo_q;
  logic signed [MW-1:0]   sx, sy;

  // Clamp the requested degree to the build limit
  assign deg_in = (int'(degree_i) > MaxDegree) ? DGW'(MaxDegree) : DGW'(degree_i);
  assign km1    = k_q - DGW'(1);
  assign px_prev = px_q[km1];
  assign py_prev = py_q[km1];

  // Sequencer: load, one multiply/round pair per power, then hand over
  always_comb begin
    in_ch.ready  = (state_q == mbg_pkg::F_IDLE) ||
                   ((state_q == mbg_pkg::F_PUSH) && push_ready_i);
    push_valid_o = (state_q == mbg_pkg::F_PUSH);
    accept       = in_ch.valid & in_ch.ready;
    state_d      = state_q;
    unique case (state_q)
      mbg_pkg::F_IDLE: begin
        if (accept) begin
          state_d = (deg_in <= DGW'(1)) ? mbg_pkg::F_PUSH : mbg_pkg::F_MUL;
        end
      end
      mbg_pkg::F_MUL: begin
        state_d = mbg_pkg::F_ACC;
      end
      mbg_pkg::F_ACC: begin
        state_d = (k_q == deg_q) ? mbg_pkg::F_PUSH : mbg_pkg::F_MUL;
      end
      mbg_pkg::F_PUSH: begin
        if (push_ready_i) begin
          if (accept) begin
            state_d = (deg_in <= DGW'(1)) ? mbg_pkg::F_PUSH : mbg_pkg::F_MUL;
          end else begin
            state_d = mbg_pkg::F_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbg_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Rounded sums of the split products
  assign sx = (MW'(mx_hi_q) <<< SPL) + MW'(mx_lo_q) + HalfM;
  assign sy = (MW'(my_hi_q) <<< SPL) + MW'(my_lo_q) + HalfM;

  // Power tables
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q      <= in_ch.x_coord;
      y_q      <= in_ch.y_coord;
      jv_q     <= '{in_ch.jinv_11, in_ch.jinv_12, in_ch.jinv_21, in_ch.jinv_22};
      deg_q    <= deg_in;
      k_q      <= DGW'(2);
      px_q[0]  <= OneQ;
      py_q[0]  <= OneQ;
      px_q[1]  <= PW'(in_ch.x_coord);
      py_q[1]  <= PW'(in_ch.y_coord);
      dx_q[0]  <= '0;
      dy_q[0]  <= '0;
      dx_q[1]  <= DW'(OneQ);
      dy_q[1]  <= DW'(OneQ);
    end
    if (state_q == mbg_pkg::F_MUL) begin
      mx_hi_q   <= $signed(px_prev[PW-1:SPL]) * x_q;
      mx_lo_q   <= $signed({1'b0, px_prev[SPL-1:0]}) * x_q;
      my_hi_q   <= $signed(py_prev[PW-1:SPL]) * y_q;
      my_lo_q   <= $signed({1'b0, py_prev[SPL-1:0]}) * y_q;
      // derivative power k*x^(k-1), formed at full derivative width
      dx_q[k_q] <= DW'($signed({1'b0, k_q}) * DW'(px_prev));
      dy_q[k_q] <= DW'($signed({1'b0, k_q}) * DW'(py_prev));
    end
    if (state_q == mbg_pkg::F_ACC) begin
      px_q[k_q] <= sx[mbg_pkg::FRAC +: PW];
      py_q[k_q] <= sy[mbg_pkg::FRAC +: PW];
      if (k_q != deg_q) begin
        k_q <= k_q + DGW'(1);
      end
    end
  end

  // Pack the queue entry
  for (genvar k = 0; k <= MaxDegree; k++) begin : g_pack
    assign push_data_o[k * PW +: PW]         = px_q[k];
    assign push_data_o[OffPy + k * PW +: PW] = py_q[k];
    assign push_data_o[OffDx + k * DW +: DW] = dx_q[k];
    assign push_data_o[OffDy + k * DW +: DW] = dy_q[k];
  end
  assign push_data_o[OffJ +: 4 * CW]  = jv_q;
  assign push_data_o[OffDg +: DGW]    = deg_q;

endmodule

// ===== rtl/mbg_back.sv =====
// Back end: walks the monomials of the head entry through a product pipeline.
module mbg_back #(
  parameter  int MaxDegree = mbg_pkg::MAX_DEGREE_DEF,
  localparam int EntryW    = mbg_pkg::entry_w(MaxDegree)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  logic [EntryW-1:0] head_data_i,
  output logic              pop_o,
  mbg_out_if.source         out_ch
);

  localparam int PW   = mbg_pkg::pw_of(MaxDegree);
  localparam int DW   = mbg_pkg::dw_of(MaxDegree);
  localparam int GW   = mbg_pkg::gw_of(MaxDegree);
  localparam int DGW  = mbg_pkg::dg_of(MaxDegree);
  localparam int CW   = mbg_pkg::CRD_W;
  localparam int SPL  = mbg_pkg::SPLIT;
  localparam int FR   = mbg_pkg::FRAC;
  localparam int SG   = mbg_pkg::SHIFT_G;
  localparam int IW   = mbg_pkg::IDX_W;
  localparam int PHW  = mbg_pkg::PHI_W;
  localparam int DRW  = mbg_pkg::DER_W;
  localparam int OffPy = (MaxDegree + 1) * PW;
  localparam int OffDx = 2 * (MaxDegree + 1) * PW;
  localparam int OffDy = OffDx + (MaxDegree + 1) * DW;
  localparam int OffJ  = OffDy + (MaxDegree + 1) * DW;
  localparam int OffDg = OffJ + 4 * CW;
  // Product widths
  localparam int PRW  = 2 * PW;
  localparam int GRW  = PW + DW;
  localparam int PHHW = PW - SPL + PW;
  localparam int PHLW = SPL + 1 + PW;
  localparam int GXHW = DW - SPL + PW;
  localparam int GXLW = SPL + 1 + PW;
  localparam int GYHW = PW - SPL + DW;
  localparam int GYLW = SPL + 1 + DW;
  localparam int GHW  = GW - SPL + CW;
  localparam int GLW  = SPL + 1 + CW;
  localparam int SW   = GW + CW + 1;

  localparam logic signed [PRW-1:0] HalfP = PRW'(1) <<< (FR - 1);
  localparam logic signed [GRW-1:0] HalfR = GRW'(1) <<< (FR - 1);
  localparam logic signed [SW-1:0]  HalfG = SW'(1) <<< (SG - 1);
  localparam logic signed [PHW-1:0] PhiMax = {1'b0, {(PHW-1){1'b1}}};
  localparam logic signed [PHW-1:0] PhiMin = {1'b1, {(PHW-1){1'b0}}};
  localparam logic signed [DRW-1:0] DerMax = {1'b0, {(DRW-1){1'b1}}};
  localparam logic signed [DRW-1:0] DerMin = {1'b1, {(DRW-1){1'b0}}};

  // Head entry fields
  logic signed [PW-1:0] px [MaxDegree+1];
  logic signed [PW-1:0] py [MaxDegree+1];
  logic signed [DW-1:0] dx [MaxDegree+1];
  logic signed [DW-1:0] dy [MaxDegree+1];
  mbg_pkg::jinv_t       jv_h;
  logic [DGW-1:0]       deg_h;

  for (genvar k = 0; k <= MaxDegree; k++) begin : g_unpack
    assign px[k] = head_data_i[k * PW +: PW];
    assign py[k] = head_data_i[OffPy + k * PW +: PW];
    assign dx[k] = head_data_i[OffDx + k * DW +: DW];
    assign dy[k] = head_data_i[OffDy + k * DW +: DW];
  end
  assign jv_h  = head_data_i[OffJ +: 4 * CW];
  assign deg_h = head_data_i[OffDg +: DGW];

  // Monomial walk
  logic [DGW-1:0] i_q, j_q, a_sel;
  logic [IW-1:0]  n_q;
  logic           en, issue, last_c;

  assign en     = ~out_ch.valid | out_ch.ready;
  assign issue  = head_valid_i & en;
  assign last_c = (i_q == deg_h) && (j_q == i_q);
  assign pop_o  = issue & last_c;
  assign a_sel  = i_q - j_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
      n_q <= '0;
    end else if (issue) begin
      if (last_c) begin
        i_q <= '0;
        j_q <= '0;
        n_q <= '0;
      end else begin
        n_q <= n_q + IW'(1);
        if (j_q == i_q) begin
          i_q <= i_q + DGW'(1);
          j_q <= '0;
        end else begin
          j_q <= j_q + DGW'(1);
        end
      end
    end
  end

  // Stage valids and side fields
  logic           v_q    [1:6];
  logic [IW-1:0]  idx_q  [1:6];
  logic           last_q [1:6];
  mbg_pkg::jinv_t jv_q   [1:4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= 6; s++) begin
        v_q[s] <= 1'b0;
      end
      out_ch.valid <= 1'b0;
    end else if (en) begin
      v_q[1] <= head_valid_i;
      for (int s = 2; s <= 6; s++) begin
        v_q[s] <= v_q[s-1];
      end
      out_ch.valid <= v_q[6];
    end
  end

  // Datapath registers
  logic signed [PW-1:0]   px1_q, py1_q;
  logic signed [DW-1:0]   dx1_q, dy1_q;
  logic signed [PHHW-1:0] ph_hi_q;
  logic signed [PHLW-1:0] ph_lo_q;
  logic signed [GXHW-1:0] gx_hi_q;
  logic signed [GXLW-1:0] gx_lo_q;
  logic signed [GYHW-1:0] gy_hi_q;
  logic signed [GYLW-1:0] gy_lo_q;
  logic signed [PRW-1:0]  phs_q;
  logic signed [GRW-1:0]  gxs_q, gys_q;
  logic signed [PHW-1:0]  phi4_q, phi5_q, phi6_q;
  logic                   ps4_q, ps5_q, ps6_q;
  logic signed [GW-1:0]   gx4_q, gy4_q;
  logic signed [GHW-1:0]  x1h_q, x2h_q, y1h_q, y2h_q;
  logic signed [GLW-1:0]  x1l_q, x2l_q, y1l_q, y2l_q;
  logic signed [SW-1:0]   oxs_q, oys_q;

  logic [PRW-1:FR+PHW-1]  ph_top;
  logic [SW-1:SG+DRW-1]   ox_top, oy_top;
  logic                   ph_fit, ox_fit, oy_fit;

  // Range checks ahead of saturation
  assign ph_top = phs_q[PRW-1:FR+PHW-1];
  assign ox_top = oxs_q[SW-1:SG+DRW-1];
  assign oy_top = oys_q[SW-1:SG+DRW-1];
  assign ph_fit = (&ph_top) | ~(|ph_top);
  assign ox_fit = (&ox_top) | ~(|ox_top);
  assign oy_fit = (&oy_top) | ~(|oy_top);

  always_ff @(posedge clk_i) begin
    if (en) begin
      // side fields
      idx_q[1]  <= n_q;
      last_q[1] <= last_c;
      jv_q[1]   <= jv_h;
      for (int s = 2; s <= 6; s++) begin
        idx_q[s]  <= idx_q[s-1];
        last_q[s] <= last_q[s-1];
      end
      for (int s = 2; s <= 4; s++) begin
        jv_q[s] <= jv_q[s-1];
      end

      // select operands of this monomial
      px1_q <= px[a_sel];
      py1_q <= py[j_q];
      dx1_q <= dx[a_sel];
      dy1_q <= dy[j_q];

      // split local products
      ph_hi_q <= $signed(px1_q[PW-1:SPL]) * py1_q;
      ph_lo_q <= $signed({1'b0, px1_q[SPL-1:0]}) * py1_q;
      gx_hi_q <= $signed(dx1_q[DW-1:SPL]) * py1_q;
      gx_lo_q <= $signed({1'b0, dx1_q[SPL-1:0]}) * py1_q;
      gy_hi_q <= $signed(px1_q[PW-1:SPL]) * dy1_q;
      gy_lo_q <= $signed({1'b0, px1_q[SPL-1:0]}) * dy1_q;

      // recombine and add half an LSB
      phs_q <= (PRW'(ph_hi_q) <<< SPL) + PRW'(ph_lo_q) + HalfP;
      gxs_q <= (GRW'(gx_hi_q) <<< SPL) + GRW'(gx_lo_q) + HalfR;
      gys_q <= (GRW'(gy_hi_q) <<< SPL) + GRW'(gy_lo_q) + HalfR;

      // value saturates, local gradient is kept whole
      if (ph_fit) begin
        phi4_q <= phs_q[FR +: PHW];
      end else begin
        phi4_q <= phs_q[PRW-1] ? PhiMin : PhiMax;
      end
      ps4_q <= ~ph_fit;
      gx4_q <= gxs_q[FR +: GW];
      gy4_q <= gys_q[FR +: GW];

      // split global products
      x1h_q  <= $signed(gx4_q[GW-1:SPL]) * jv_q[4].j11;
      x2h_q  <= $signed(gy4_q[GW-1:SPL]) * jv_q[4].j12;
      x1l_q  <= $signed({1'b0, gx4_q[SPL-1:0]}) * jv_q[4].j11;
      x2l_q  <= $signed({1'b0, gy4_q[SPL-1:0]}) * jv_q[4].j12;
      y1h_q  <= $signed(gx4_q[GW-1:SPL]) * jv_q[4].j21;
      y2h_q  <= $signed(gy4_q[GW-1:SPL]) * jv_q[4].j22;
      y1l_q  <= $signed({1'b0, gx4_q[SPL-1:0]}) * jv_q[4].j21;
      y2l_q  <= $signed({1'b0, gy4_q[SPL-1:0]}) * jv_q[4].j22;
      phi5_q <= phi4_q;
      ps5_q  <= ps4_q;

      // exact dot products plus rounding offset
      oxs_q  <= ((SW'(x1h_q) + SW'(x2h_q)) <<< SPL) + SW'(x1l_q) + SW'(x2l_q) + HalfG;
      oys_q  <= ((SW'(y1h_q) + SW'(y2h_q)) <<< SPL) + SW'(y1l_q) + SW'(y2l_q) + HalfG;
      phi6_q <= phi5_q;
      ps6_q  <= ps5_q;

      // output register
      out_ch.basis_index <= idx_q[6];
      out_ch.last_of_run <= last_q[6];
      out_ch.phi_value   <= phi6_q;
      out_ch.dphi_dx     <= ox_fit ? oxs_q[SG +: DRW] : (oxs_q[SW-1] ? DerMin : DerMax);
      out_ch.dphi_dy     <= oy_fit ? oys_q[SG +: DRW] : (oys_q[SW-1] ? DerMin : DerMax);
      out_ch.saturated   <= ps6_q | ~ox_fit | ~oy_fit;
    end
  end

endmodule

// ===== rtl/monomial_basis_with_gradient.sv =====
// Top level: degree register, power builder, queue and basis pipeline.
//
// Usage:
//   in_ch carries one point per beat: x_coord, y_coord (Q2.30) and the four
//   inverse Jacobian entries (Q16.16). out_ch returns, per point, one beat per
//   monomial x^a*y^b of total degree 0..degree, in order of rising degree and
//   rising power of y, with basis_index, phi_value (Q2.30), dphi_dx and dphi_dy
//   (Q24.24) and last_of_run on the final beat. Clipped results set saturated.
//   The degree register is written over cfg_* and is clamped to MaxDegree;
//   write it only while the block is idle. It resets to one.
//   Flow: at degree two and above the power builder does one split multiply and
//   one rounding add per power, then the hand-over; below that it hands over
//   directly. It takes no new point while building one, and it queues up to two
//   built points. The basis pipeline issues one monomial per cycle while out_ch
//   is not stalled, and a point gives (degree+1)*(degree+2)/2 beats there, 15 at
//   degree four. Sustained throughput is set by the slower of the power builder
//   and the basis pipeline.
//   Reset empties the queue and the pipeline. When out_ch stalls, the whole
//   basis pipeline holds; the front keeps building until the queue is full.
module monomial_basis_with_gradient #(
  parameter int MaxDegree = mbg_pkg::MAX_DEGREE_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [mbg_pkg::CFG_W-1:0] cfg_degree_i,
  mbg_in_if.sink                    in_ch,
  mbg_out_if.source                 out_ch
);

  localparam int EntryW = mbg_pkg::entry_w(MaxDegree);

  logic [mbg_pkg::CFG_W-1:0] degree_q;
  logic                      push_valid, push_ready, head_valid, pop;
  logic [EntryW-1:0]         push_data, head_data;

  // Degree register, one beat per write
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= mbg_pkg::DEGREE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      degree_q <= cfg_degree_i;
    end
  end

  mbg_front #(
    .MaxDegree (MaxDegree)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .degree_i     (degree_q),
    .in_ch        (in_ch),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  mbg_fifo #(
    .Width (EntryW)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .head_valid_o (head_valid),
    .head_data_o  (head_data),
    .pop_i        (pop)
  );

  mbg_back #(
    .MaxDegree (MaxDegree)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .out_ch       (out_ch)
  );

endmodule
